// ===== sv/advection_term_stencil_core_defines.svh =====
// Assertion macros for the advection stencil core.
// Used by advection_term_stencil_core; no other dependencies.
`ifndef ADVECTION_TERM_STENCIL_CORE_DEFINES_SVH
`define ADVECTION_TERM_STENCIL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ATS_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("ats assertion failed");
`define ATS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("ats assertion failed");
`else
`define ATS_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define ATS_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== sv/ats_pkg.sv =====
// Shared constants, register codes and helpers of the advection stencil core.
// No dependencies.
package ats_pkg;

	localparam int VEL_W          = 16;
	localparam int ADV_W          = 32;
	localparam int SIZE_W         = 7;
	localparam int SCALE_W        = 16;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 16;
	localparam int SIZE_X_LIMIT   = 64;
	localparam int SIZE_RESET     = 64;
	localparam int SCALE_RESET    = 256;
	localparam int ROUND_SHIFT    = 19;

	localparam int MAX_SIZE_Y_DEF  = 64;
	localparam int MAX_SIZE_Z_DEF  = 64;
	localparam int GUARD_WIDTH_DEF = 1;
	localparam int SAMPLE_BITS_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE_X = 4'd0,
		CFG_SIZE_Y = 4'd1,
		CFG_SIZE_Z = 4'd2,
		CFG_SCALE  = 4'd3
	} cfg_idx_t;

	// Map a size of zero to one and clip to the axis maximum.
	function automatic logic [15:0] clamp_size(input logic [SIZE_W-1:0] v, input int hi);
		logic [15:0] r;
		r = {{(16-SIZE_W){1'b0}}, v};
		if (r == 16'd0) r = 16'd1;
		if (r > 16'(hi)) r = 16'(hi);
		return r;
	endfunction

endpackage

// ===== sv/ats_ifs.sv =====
// Channel interfaces of the advection stencil core: velocity in, result out, config.
// Depends on ats_pkg.
interface ats_vel_if import ats_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic signed [VEL_W-1:0] vel_z;
	modport source(output valid, vel_x, vel_y, vel_z, input ready);
	modport sink(input valid, vel_x, vel_y, vel_z, output ready);
endinterface

interface ats_adv_if import ats_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ADV_W-1:0] adv_x;
	logic signed [ADV_W-1:0] adv_y;
	logic signed [ADV_W-1:0] adv_z;
	logic                    last_point;
	logic                    clipped;
	modport source(output valid, adv_x, adv_y, adv_z, last_point, clipped, input ready);
	modport sink(input valid, adv_x, adv_y, adv_z, last_point, clipped, output ready);
endinterface

interface ats_cfg_if import ats_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/ats_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ats_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8713
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/advection_term_stencil_core.sv =====
// Advection-term central-difference stencil over a guard-padded 3D grid.
// Velocity beats enter on vel, results leave on adv, registers are written on cfg.
// Depends on ats_pkg, ats_ifs, ats_ram and the assertion macro header.
//
// Usage: stream every padded grid sample (x slowest, z fastest) on vel. For each
// interior point one beat leaves on adv, produced by the beat that carries the
// point's +x neighbor; guard samples yield nothing. last_point marks the final
// interior point, clipped marks saturation of any component.
// Throughput: one vel beat per cycle except during a stall. Five register stages:
// ring read, products, difference sum, split scale products, round/saturate into
// the output register; the first stage loads on the edge that accepts the beat.
// The sample window is five copies of a ring RAM of 2*PY_MAX*PZ_MAX+1 entries, one
// read port per neighbor tap; a fill count makes never-written entries read as zero.
// Reset: sizes 64, scale 1.0, positions and fill count zero; no clearing pass.
// Stall: while an output beat waits, the whole pipeline holds and vel.ready is
// low; nothing is lost or repeated. cfg.ready is always high; write registers
// only while the block is idle.
`include "advection_term_stencil_core_defines.svh"
module advection_term_stencil_core import ats_pkg::*; #(
	parameter int MAX_SIZE_Y  = MAX_SIZE_Y_DEF,
	parameter int MAX_SIZE_Z  = MAX_SIZE_Z_DEF,
	parameter int GUARD_WIDTH = GUARD_WIDTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ats_vel_if.sink    vel,
	ats_adv_if.source  adv,
	ats_cfg_if.sink    cfg
);

	localparam int SB        = SAMPLE_BITS;
	localparam int PX_MAX    = SIZE_X_LIMIT + 2 * GUARD_WIDTH;
	localparam int PY_MAX    = MAX_SIZE_Y + 2 * GUARD_WIDTH;
	localparam int PZ_MAX    = MAX_SIZE_Z + 2 * GUARD_WIDTH;
	localparam int XW        = $clog2(PX_MAX + 2);
	localparam int YW        = $clog2(PY_MAX + 2);
	localparam int ZW        = $clog2(PZ_MAX + 2);
	localparam int RING      = 2 * PY_MAX * PZ_MAX + 1;
	localparam int AW        = $clog2(RING);
	localparam int NW        = $clog2(RING + 1);
	localparam int PW        = 2 * SB;
	localparam int SW        = PW + 3;
	localparam int LO_W      = SW / 2;
	localparam int HW        = SW - LO_W;
	localparam int EW        = SW + SCALE_W + 1;
	localparam int NTAP      = 5;

	typedef logic signed [SB-1:0] samp_t;
	typedef samp_t                vec_t [3];

	// Tap order: -x, +y, -y, +z, -z
	localparam int TAP_XM = 0;
	localparam int TAP_YP = 1;
	localparam int TAP_YM = 2;
	localparam int TAP_ZP = 3;
	localparam int TAP_ZM = 4;

	// Configuration registers
	logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic [SCALE_W-1:0] scale_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(SIZE_RESET);
			size_y_q <= SIZE_W'(SIZE_RESET);
			size_z_q <= SIZE_W'(SIZE_RESET);
			scale_q  <= SCALE_W'(SCALE_RESET);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SIZE_X: size_x_q <= cfg.data[SIZE_W-1:0];
				CFG_SIZE_Y: size_y_q <= cfg.data[SIZE_W-1:0];
				CFG_SIZE_Z: size_z_q <= cfg.data[SIZE_W-1:0];
				CFG_SCALE:  scale_q  <= cfg.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective sizes, padded extents and tap offsets
	logic [XW-1:0] sx, px;
	logic [YW-1:0] sy, py;
	logic [ZW-1:0] sz, pz;
	logic [NW-1:0] plane;
	logic [NW-1:0] tap_off [NTAP];

	always_comb begin
		sx = XW'(clamp_size(size_x_q, SIZE_X_LIMIT));
		sy = YW'(clamp_size(size_y_q, MAX_SIZE_Y));
		sz = ZW'(clamp_size(size_z_q, MAX_SIZE_Z));
		px = sx + XW'(2 * GUARD_WIDTH);
		py = sy + YW'(2 * GUARD_WIDTH);
		pz = sz + ZW'(2 * GUARD_WIDTH);
		plane = NW'(py) * NW'(pz);
		tap_off[TAP_XM] = NW'(plane << 1);
		tap_off[TAP_YP] = plane - NW'(pz);
		tap_off[TAP_YM] = plane + NW'(pz);
		tap_off[TAP_ZP] = plane - NW'(1);
		tap_off[TAP_ZM] = plane + NW'(1);
	end

	// Handshake and global pipeline enable
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en, acc;

	assign en        = !v_s5 || adv.ready;
	assign vel.ready = en;
	assign acc       = vel.valid && en;

	// Position of the incoming sample
	logic [XW-1:0] ps_q;
	logic [YW-1:0] pm_q;
	logic [ZW-1:0] pf_q;
	logic          interior, last_pt;

	always_comb begin
		interior = (ps_q >= XW'(GUARD_WIDTH + 1)) && (ps_q <= sx + XW'(GUARD_WIDTH)) &&
			(pm_q >= YW'(GUARD_WIDTH)) && (pm_q < sy + YW'(GUARD_WIDTH)) &&
			(pf_q >= ZW'(GUARD_WIDTH)) && (pf_q < sz + ZW'(GUARD_WIDTH));
		last_pt = (ps_q == sx + XW'(GUARD_WIDTH)) &&
			(pm_q == sy + YW'(GUARD_WIDTH - 1)) &&
			(pf_q == sz + ZW'(GUARD_WIDTH - 1));
	end

	// Advance raster position, ring write pointer and fill count
	logic [AW-1:0] wr_q;
	logic [NW-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q   <= '0;
			pm_q   <= '0;
			pf_q   <= '0;
			wr_q   <= '0;
			fill_q <= '0;
		end else if (acc) begin
			if (({1'b0, pf_q} + (ZW + 1)'(1)) >= {1'b0, pz}) begin
				pf_q <= '0;
				if (({1'b0, pm_q} + (YW + 1)'(1)) >= {1'b0, py}) begin
					pm_q <= '0;
					if (({1'b0, ps_q} + (XW + 1)'(1)) >= {1'b0, px}) begin
						ps_q <= '0;
					end else begin
						ps_q <= ps_q + XW'(1);
					end
				end else begin
					pm_q <= pm_q + YW'(1);
				end
			end else begin
				pf_q <= pf_q + ZW'(1);
			end
			wr_q <= (wr_q == AW'(RING - 1)) ? '0 : wr_q + AW'(1);
			if (fill_q != NW'(RING)) begin
				fill_q <= fill_q + NW'(1);
			end
		end
	end

	// Incoming sample, truncated or widened to the sample width
	samp_t cur_x, cur_y, cur_z;
	logic [31:0] ext_x, ext_y, ext_z;

	always_comb begin
		ext_x = {16'b0, vel.vel_x};
		ext_y = {16'b0, vel.vel_y};
		ext_z = {16'b0, vel.vel_z};
		cur_x = ext_x[SB-1:0];
		cur_y = ext_y[SB-1:0];
		cur_z = ext_z[SB-1:0];
	end

	// Ring copies, one read port per neighbor tap
	logic [AW-1:0]   raddr [NTAP];
	logic [3*SB-1:0] rdata [NTAP];
	logic [NTAP-1:0] tap_ok;

	always_comb begin
		for (int t = 0; t < NTAP; t++) begin
			if (NW'(wr_q) >= tap_off[t]) begin
				raddr[t] = AW'(NW'(wr_q) - tap_off[t]);
			end else begin
				raddr[t] = AW'(NW'(wr_q) + (NW'(RING) - tap_off[t]));
			end
			tap_ok[t] = tap_off[t] <= fill_q;
		end
	end

	for (genvar t = 0; t < NTAP; t++) begin : g_ring
		ats_ram #(
			.WIDTH(3 * SB),
			.DEPTH(RING)
		) u_ring (
			.clk  (clk),
			.we   (acc),
			.waddr(wr_q),
			.wdata({cur_z, cur_y, cur_x}),
			.re   (en),
			.raddr(raddr[t]),
			.rdata(rdata[t])
		);
	end

	// Stage 1: current sample and flags, aligned with ring read data
	vec_t            cur_s1;
	logic            last_s1;
	logic [NTAP-1:0] tap_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && interior;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_s1[0] <= cur_x;
			cur_s1[1] <= cur_y;
			cur_s1[2] <= cur_z;
			last_s1   <= last_pt;
			tap_ok_s1 <= tap_ok;
		end
	end

	// Stage 2: the eighteen products v_c * v_d
	vec_t                 nb [6];
	logic signed [PW-1:0] prod_s2 [6][3];
	logic                 last_s2;

	always_comb begin
		nb[0] = cur_s1;
		for (int t = 0; t < NTAP; t++) begin
			for (int c = 0; c < 3; c++) begin
				nb[t+1][c] = tap_ok_s1[t] ? rdata[t][c*SB +: SB] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 6; n++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[n][c] <= nb[n][c] * nb[n][n/2];
				end
			end
			last_s2 <= last_s1;
		end
	end

	// Stage 3: signed differences summed per component
	logic signed [SW-1:0] sum_s3 [3];
	logic                 last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sum_s3[c] <= SW'(prod_s2[0][c]) - SW'(prod_s2[1][c])
					+ SW'(prod_s2[2][c]) - SW'(prod_s2[3][c])
					+ SW'(prod_s2[4][c]) - SW'(prod_s2[5][c]);
			end
			last_s3 <= last_s2;
		end
	end

	// Stage 4: scale as low and high partial products
	logic signed [LO_W+SCALE_W+1:0] pl_s4 [3];
	logic signed [HW+SCALE_W:0]     ph_s4 [3];
	logic                           last_s4;
	logic signed [SCALE_W:0]        scale_s;

	assign scale_s = $signed({1'b0, scale_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pl_s4[c] <= $signed({1'b0, sum_s3[c][LO_W-1:0]}) * scale_s;
				ph_s4[c] <= $signed(sum_s3[c][SW-1:LO_W]) * scale_s;
			end
			last_s4 <= last_s3;
		end
	end

	// Stage 5: recombine, round half up, saturate into the output register
	logic signed [EW-1:0]    full [3];
	logic signed [EW-1:0]    rnd [3];
	logic signed [ADV_W-1:0] sat [3];
	logic [2:0]              clip;
	logic signed [ADV_W-1:0] adv_s5 [3];
	logic                    last_s5, clip_s5;

	localparam logic signed [EW-1:0] SAT_HI = EW'({1'b0, {(ADV_W-1){1'b1}}});
	localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			full[c] = (EW'(ph_s4[c]) <<< LO_W) + EW'(pl_s4[c])
				+ EW'(1 << (ROUND_SHIFT - 1));
			rnd[c] = full[c] >>> ROUND_SHIFT;
			clip[c] = 1'b0;
			if (rnd[c] > SAT_HI) begin
				sat[c]  = SAT_HI[ADV_W-1:0];
				clip[c] = 1'b1;
			end else if (rnd[c] < SAT_LO) begin
				sat[c]  = SAT_LO[ADV_W-1:0];
				clip[c] = 1'b1;
			end else begin
				sat[c] = rnd[c][ADV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				adv_s5[c] <= sat[c];
			end
			last_s5 <= last_s4;
			clip_s5 <= |clip;
		end
	end

	assign adv.valid      = v_s5;
	assign adv.adv_x      = adv_s5[0];
	assign adv.adv_y      = adv_s5[1];
	assign adv.adv_z      = adv_s5[2];
	assign adv.last_point = last_s5;
	assign adv.clipped    = clip_s5;

	// Checks
	`ATS_ASSERT_IMPLY(a_fill_bound, clk, arst_n, 1'b1, fill_q <= NW'(RING))
	`ATS_ASSERT_NEXT(a_wr_advance, clk, arst_n, acc && (wr_q != AW'(RING - 1)), wr_q == $past(wr_q) + AW'(1))
	`ATS_ASSERT_IMPLY(a_stall_blocks_input, clk, arst_n, adv.valid && !adv.ready, !vel.ready)

endmodule
